// ----- rtl/core/serial_loaded_bank_mapper_core_assert.svh -----
// assertion macros shared by the mapper checker
`ifndef SERIAL_LOADED_BANK_MAPPER_CORE_ASSERT_SVH
`define SERIAL_LOADED_BANK_MAPPER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SLBM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SLBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/slbm_pkg.sv -----
// shared types and codes of the serial loaded bank mapper
package slbm_pkg;

  typedef enum logic [2:0] {
    TGT_PRG_ROM = 3'd0,
    TGT_PRG_RAM = 3'd1,
    TGT_CHR_ROM = 3'd2,
    TGT_CHR_RAM = 3'd3,
    TGT_NONE    = 3'd4
  } target_e;

  localparam logic [1:0] OP_CPU_WRITE = 2'd0;
  localparam logic [1:0] OP_CPU_READ  = 2'd1;
  localparam logic [1:0] OP_PPU_READ  = 2'd2;

  // internal register picked by address bits 14-13
  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_CHR0    = 2'd1;
  localparam logic [1:0] SEL_CHR1    = 2'd2;
  localparam logic [1:0] SEL_PRG     = 2'd3;

  // prg modes that pin one 16K window, the 32K modes sit below them
  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_PRG_LOG2    = 2'd0;
  localparam logic [1:0] CFG_CHR_ROM     = 2'd1;
  localparam logic [1:0] CFG_PRG_RAM     = 2'd2;

  localparam int unsigned CFG_DATA_W  = 3;
  localparam int unsigned OFFSET_W    = 18;
  localparam logic [2:0]  PRG_LOG2_MAX = 3'd4;
  localparam logic [2:0]  PRG_LOG2_RST = 3'd3;

  // bank wrap mask for a log2 bank count, saturating at sixteen banks
  function automatic logic [4:0] prg_mask(input logic [2:0] lg);
    logic [2:0] sat;
    sat = (lg > PRG_LOG2_MAX) ? PRG_LOG2_MAX : lg;
    return ~(5'h1F << sat);
  endfunction

endpackage

// ----- rtl/core/serial_loaded_bank_mapper_core.sv -----
// top level of the serial loaded bank mapper
// Serially loaded cartridge bank mapper. Each request is either a CPU write
// (bit 0 of the data shifts into a 5-bit serial register, bit 7 clears it,
// the fifth bit loads control, CHR bank 0, CHR bank 1 or PRG bank chosen by
// address bits 14-13) or a CPU/PPU read to translate into a PRG ROM, PRG RAM,
// CHR ROM or CHR RAM offset. Every request gives exactly one result, in the
// cycle after it is accepted, carrying the mirroring and work RAM enable as
// they stand after that request. One request is taken every cycle: the bank
// state is a handful of flops and translation is a mux and a concatenation in
// front of the result register. A new request is held off only while the
// result register is full and the consumer stalls. No clearing pass is needed
// after reset. Only the user keeps configuration writes on cfg_we_i to idle.
module serial_loaded_bank_mapper_core
  import slbm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            opcode_i,
  input  logic [15:0]           address_i,
  input  logic [7:0]            write_data_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            target_o,
  output logic [OFFSET_W-1:0]   offset_o,
  output logic [1:0]            mirroring_o,
  output logic                  prg_ram_on_o
);

  // cartridge description
  logic [2:0] prg_log2_q, prg_log2_d;
  logic       chr_rom_q, chr_rom_d;
  logic       prg_ram_present_q, prg_ram_present_d;

  // mapper state
  logic [4:0] shift_value_q, shift_value_d;
  logic [2:0] shift_count_q, shift_count_d;
  logic [1:0] mirror_q, mirror_d;
  logic [1:0] prg_mode_q, prg_mode_d;
  logic       chr_8k_q, chr_8k_d;
  logic [4:0] prg_low_q, prg_low_d;
  logic [4:0] prg_high_q, prg_high_d;
  logic [4:0] chr_low_q, chr_low_d;
  logic [4:0] chr_high_q, chr_high_d;
  logic       wram_q, wram_d, wram_step;

  // result register
  logic                out_valid_q;
  target_e             target_q, target_d;
  logic [OFFSET_W-1:0] offset_q, offset_d;
  logic [1:0]          mirroring_q;
  logic                prg_ram_on_q;

  logic       in_accept;
  logic       is_serial;
  logic [4:0] shift_next;
  logic [2:0] count_next;
  logic [4:0] prg_bank;
  logic [4:0] chr_bank;
  target_e    cpu_tgt, ppu_tgt;
  logic [OFFSET_W-1:0] cpu_off, ppu_off;

  // only a full, stalled result register blocks a new request
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_serial  = (opcode_i == OP_CPU_WRITE) && address_i[15];

  assign shift_next = {write_data_i[0], shift_value_q[4:1]};
  assign count_next = shift_count_q + 3'd1;

  // state update from the serial port, then configuration writes on top
  always_comb begin
    shift_value_d = shift_value_q;
    shift_count_d = shift_count_q;
    mirror_d      = mirror_q;
    prg_mode_d    = prg_mode_q;
    chr_8k_d      = chr_8k_q;
    prg_low_d     = prg_low_q;
    prg_high_d    = prg_high_q;
    chr_low_d     = chr_low_q;
    chr_high_d    = chr_high_q;
    wram_step     = wram_q;

    if (in_accept && is_serial) begin
      if (write_data_i[7]) begin
        // serial reset also forces the fixed-last-bank prg mode
        shift_value_d = 5'd0;
        shift_count_d = 3'd0;
        prg_mode_d    = PRG_MODE_FIX_LAST;
      end else if (count_next >= 3'd5) begin
        shift_value_d = 5'd0;
        shift_count_d = 3'd0;
        case (address_i[14:13])
          SEL_CONTROL: begin
            mirror_d   = shift_next[1:0];
            prg_mode_d = shift_next[3:2];
            chr_8k_d   = !shift_next[4];
          end
          SEL_CHR0: begin
            if (chr_8k_q) begin
              // 8k mode drops the low bit and sets both halves
              chr_low_d  = {shift_next[4:1], 1'b0};
              chr_high_d = {shift_next[4:1], 1'b1};
            end else begin
              chr_low_d = shift_next;
            end
          end
          SEL_CHR1: begin
            if (!chr_8k_q) begin
              chr_high_d = shift_next;
            end
          end
          SEL_PRG: begin
            if (prg_mode_q < PRG_MODE_FIX_FIRST) begin
              prg_low_d  = {1'b0, shift_next[3:1], 1'b0};
              prg_high_d = {1'b0, shift_next[3:1], 1'b1};
            end else begin
              prg_low_d  = {1'b0, shift_next[3:0]};
              prg_high_d = {1'b0, shift_next[3:0]};
            end
            wram_step = !shift_next[4];
          end
          default: begin
            wram_step = wram_q;
          end
        endcase
      end else begin
        shift_value_d = shift_next;
        shift_count_d = count_next;
      end
    end

    prg_log2_d        = prg_log2_q;
    chr_rom_d         = chr_rom_q;
    prg_ram_present_d = prg_ram_present_q;
    wram_d            = wram_step;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRG_LOG2: begin
          // new bank count also reloads the upper prg bank to the last one
          prg_log2_d = cfg_data_i[2:0];
          prg_high_d = prg_mask(cfg_data_i[2:0]);
        end
        CFG_CHR_ROM: begin
          chr_rom_d = cfg_data_i[0];
        end
        CFG_PRG_RAM: begin
          prg_ram_present_d = cfg_data_i[0];
          wram_d            = cfg_data_i[0];
        end
        default: begin
          prg_log2_d = prg_log2_q;
        end
      endcase
    end
  end

  // cpu side translation from the current bank state
  always_comb begin
    if (!address_i[14]) begin
      prg_bank = (prg_mode_q == PRG_MODE_FIX_FIRST) ? 5'd0 : prg_low_q;
    end else begin
      prg_bank = (prg_mode_q == PRG_MODE_FIX_LAST) ? 5'h1F : prg_high_q;
    end
    prg_bank = prg_bank & prg_mask(prg_log2_q);

    if (address_i[15]) begin
      cpu_tgt = TGT_PRG_ROM;
      cpu_off = {prg_bank[3:0], address_i[13:0]};
    end else if ((address_i inside {[16'h6000:16'h7FFF]}) && wram_q) begin
      cpu_tgt = TGT_PRG_RAM;
      cpu_off = {5'd0, address_i[12:0]};
    end else begin
      cpu_tgt = TGT_NONE;
      cpu_off = '0;
    end
  end

  // ppu side translation: two 4k chr banks or flat 8k ram
  always_comb begin
    chr_bank = address_i[12] ? chr_high_q : chr_low_q;
    if (address_i[15:13] != 3'd0) begin
      ppu_tgt = TGT_NONE;
      ppu_off = '0;
    end else if (chr_rom_q) begin
      ppu_tgt = TGT_CHR_ROM;
      ppu_off = {1'b0, chr_bank, address_i[11:0]};
    end else begin
      ppu_tgt = TGT_CHR_RAM;
      ppu_off = {5'd0, address_i[12:0]};
    end
  end

  // result select; serial writes and the unused opcode report none
  always_comb begin
    case (opcode_i)
      OP_CPU_WRITE: begin
        target_d = address_i[15] ? TGT_NONE : cpu_tgt;
        offset_d = address_i[15] ? '0 : cpu_off;
      end
      OP_CPU_READ: begin
        target_d = cpu_tgt;
        offset_d = cpu_off;
      end
      OP_PPU_READ: begin
        target_d = ppu_tgt;
        offset_d = ppu_off;
      end
      default: begin
        target_d = TGT_NONE;
        offset_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_log2_q        <= PRG_LOG2_RST;
      chr_rom_q         <= 1'b1;
      prg_ram_present_q <= 1'b1;
      shift_value_q     <= 5'd0;
      shift_count_q     <= 3'd0;
      mirror_q          <= 2'd0;
      prg_mode_q        <= PRG_MODE_FIX_LAST;
      chr_8k_q          <= 1'b1;
      prg_low_q         <= 5'd0;
      prg_high_q        <= prg_mask(PRG_LOG2_RST);
      chr_low_q         <= 5'd0;
      chr_high_q        <= 5'd1;
      wram_q            <= 1'b1;
      out_valid_q       <= 1'b0;
    end else begin
      prg_log2_q        <= prg_log2_d;
      chr_rom_q         <= chr_rom_d;
      prg_ram_present_q <= prg_ram_present_d;
      shift_value_q     <= shift_value_d;
      shift_count_q     <= shift_count_d;
      mirror_q          <= mirror_d;
      prg_mode_q        <= prg_mode_d;
      chr_8k_q          <= chr_8k_d;
      prg_low_q         <= prg_low_d;
      prg_high_q        <= prg_high_d;
      chr_low_q         <= chr_low_d;
      chr_high_q        <= chr_high_d;
      wram_q            <= wram_d;
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded only on an accepted request
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      target_q     <= target_d;
      offset_q     <= offset_d;
      mirroring_q  <= mirror_d;
      prg_ram_on_q <= wram_step;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign target_o     = target_q;
  assign offset_o     = offset_q;
  assign mirroring_o  = mirroring_q;
  assign prg_ram_on_o = prg_ram_on_q;

endmodule

// ----- rtl/core/slbm_checker.sv -----
// port level checks of the mapper core and their bind
`include "serial_loaded_bank_mapper_core_assert.svh"

module slbm_checker
  import slbm_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [2:0]            target_o,
  input logic [OFFSET_W-1:0]   offset_o,
  input logic [1:0]            mirroring_o,
  input logic                  prg_ram_on_o
);

  `SLBM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                    out_valid_o && $stable(target_o) && $stable(offset_o)
                    && $stable(mirroring_o), "stalled result changed")

  `SLBM_ASSERT_IMPL(a_stall_backed, clk_i, rst_ni, in_stall_o,
                    out_valid_o && out_stall_i, "request stalled without a blocked result")

  `SLBM_ASSERT_NEXT(a_accept_result, clk_i, rst_ni, in_valid_i && !in_stall_o,
                    out_valid_o, "accepted request gave no result")

  `SLBM_ASSERT_IMPL(a_ram_enabled, clk_i, rst_ni,
                    out_valid_o && (target_o == TGT_PRG_RAM), prg_ram_on_o,
                    "work ram target while disabled")

  `SLBM_ASSERT_IMPL(a_none_zero, clk_i, rst_ni,
                    out_valid_o && (target_o == TGT_NONE), offset_o == '0,
                    "no target but nonzero offset")

endmodule

bind serial_loaded_bank_mapper_core slbm_checker u_slbm_checker (.*);
